FILE: design/sdfw_pkg.sv
package sdfw_pkg;

    localparam int DATA_W    = 32;
    localparam int SUM_W     = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SELF_WEIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WALL_INV_0  = 3'd1;

    localparam logic [1:0] KIND_SELF  = 2'd0;
    localparam logic [1:0] KIND_INNER = 2'd1;
    localparam logic [1:0] KIND_WALL  = 2'd2;

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [SUM_W-1:0]  sum_t;

    typedef struct packed {
        logic start;
        sum_t num;
        sum_t den;
    } div_req_t;

    typedef struct packed {
        logic  done;
        word_t quot;
        logic  fault;
    } div_res_t;

    function automatic sum_t add_sat(sum_t a, sum_t b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    function automatic word_t sat32(sum_t v);
        return (|v[SUM_W-1:DATA_W]) ? '1 : v[DATA_W-1:0];
    endfunction

    function automatic sum_t widen(word_t v);
        return {{(SUM_W-DATA_W){1'b0}}, v};
    endfunction

endpackage

FILE: design/sdfw_div.sv
module sdfw_div
    import sdfw_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_res_t res
);

    localparam logic [1:0] D_IDLE  = 2'd0;
    localparam logic [1:0] D_CHECK = 2'd1;
    localparam logic [1:0] D_ITER  = 2'd2;
    localparam int CNT_W = $clog2(DATA_W);

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    sum_t             num_reg, num_next;
    sum_t             den_reg, den_next;
    sum_t             rem_reg, rem_next;
    word_t            low_reg, low_next;
    word_t            quot_reg, quot_next;
    logic             fault_reg, fault_next;

    sum_t           top_part;
    logic [SUM_W:0] trial;
    logic [SUM_W:0] diff;
    logic           fits;

    // quotient bits above bit 31 are num >> (32 - FRAC_BITS) over den
    assign top_part = num_reg >> (DATA_W - FRAC_BITS);
    assign trial    = {rem_reg, low_reg[DATA_W-1]};
    assign fits     = trial >= {1'b0, den_reg};
    assign diff     = trial - {1'b0, den_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        quot_next  = quot_reg;
        fault_next = fault_reg;
        unique case (state_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    num_next   = req.num;
                    den_next   = req.den;
                    state_next = D_CHECK;
                end
            end
            D_CHECK:
            begin
                if (den_reg == '0)
                begin
                    quot_next  = '1;
                    fault_next = 1'b1;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else if (top_part >= den_reg)
                begin
                    // quotient overflows 32 bits: saturate without fault
                    quot_next  = '1;
                    fault_next = 1'b0;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    rem_next   = top_part;
                    low_next   = num_reg[DATA_W-1:0] << FRAC_BITS;
                    cnt_next   = '0;
                    fault_next = 1'b0;
                    state_next = D_ITER;
                end
            end
            D_ITER:
            begin
                rem_next  = fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
                low_next  = low_reg << 1;
                quot_next = {quot_reg[DATA_W-2:0], fits};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_W - 1))
                begin
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        low_reg   <= low_next;
        quot_reg  <= quot_next;
        fault_reg <= fault_next;
    end

    assign res.done  = done_reg;
    assign res.quot  = quot_reg;
    assign res.fault = fault_reg;

endmodule

FILE: design/shepard_density_filter_wall.sv
// Self and neighbor items pass through MUL1, MUL2 and ACC on one shared 32x32 multiplier;
// the next item is accepted in the ACC state of the one before it.
// An item with last set then runs FM1 to FM4 and two 32-step restoring divisions
// before done; a division ends early when its quotient saturates or its divisor is zero.
// done is high for one cycle; the receiver cannot stall it.
// Reset clears the sums and own values and sets all config registers to 1.0.
module shepard_density_filter_wall
    import sdfw_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int WALL_BODIES = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           item_kind,
    input  logic [DATA_W-1:0]    kernel_weight,
    input  logic [DATA_W-1:0]    density,
    input  logic [DATA_W-1:0]    volume,
    input  logic [DATA_W-1:0]    mass,
    input  logic [1:0]           wall_body,
    input  logic                 last,
    output logic                 done,
    output logic [DATA_W-1:0]    filtered_density,
    output logic [DATA_W-1:0]    new_volume,
    output logic                 divide_fault
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_MUL2 = 4'd2;
    localparam logic [3:0] S_ACC  = 4'd3;
    localparam logic [3:0] S_FM1  = 4'd4;
    localparam logic [3:0] S_FM2  = 4'd5;
    localparam logic [3:0] S_FM3  = 4'd6;
    localparam logic [3:0] S_FM4  = 4'd7;
    localparam logic [3:0] S_DIV1 = 4'd8;
    localparam logic [3:0] S_DIV2 = 4'd9;

    localparam word_t ONE = word_t'(1) << FRAC_BITS;

    word_t self_weight_reg;
    word_t wall_inv_reg [WALL_BODIES];

    logic [3:0] state_reg, state_next;
    logic       done_reg, done_next;

    logic [1:0] kind_reg;
    word_t      weight_reg, rho_reg, vol_reg, mass_reg;
    logic [1:0] body_reg;
    logic       last_reg;

    sum_t  prod_reg, prod_next;
    word_t x_reg, x_next;
    sum_t  lo_reg, lo_next;
    sum_t  mf_reg, mf_next;

    sum_t  num_sum_reg, num_sum_next;
    sum_t  den_sum_reg, den_sum_next;
    sum_t  wall_sum_reg, wall_sum_next;
    word_t own_density_reg, own_density_next;
    word_t own_mass_reg, own_mass_next;

    word_t fd_reg, fd_next;
    word_t nv_reg, nv_next;
    logic  fault_reg, fault_next;

    logic     accept;
    word_t    mul_a, mul_b;
    word_t    inv_sel;
    word_t    x_cur;
    sum_t     prod_shift;
    logic     body_ok;
    div_req_t div_req;
    div_res_t div_res;

    assign busy   = (state_reg != S_IDLE) && !(state_reg == S_ACC && !last_reg);
    assign accept = start && !busy;

    assign prod_shift = prod_reg >> FRAC_BITS;
    assign x_cur      = sat32(prod_shift);
    assign body_ok    = int'(body_reg) < WALL_BODIES;

    always_comb
    begin
        inv_sel = '0;
        for (int k = 0; k < WALL_BODIES; k++)
        begin
            if (body_reg == 2'(k))
            begin
                inv_sel = wall_inv_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_weight_reg <= ONE;
            for (int k = 0; k < WALL_BODIES; k++)
            begin
                wall_inv_reg[k] <= ONE;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_SELF_WEIGHT)
            begin
                self_weight_reg <= cfg_data;
            end
            for (int k = 0; k < WALL_BODIES; k++)
            begin
                if (cfg_index == CFG_IDX_W'(int'(REG_WALL_INV_0) + k))
                begin
                    wall_inv_reg[k] <= cfg_data;
                end
            end
        end
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MUL1:
            begin
                if (kind_reg == KIND_SELF)
                begin
                    mul_a = vol_reg;
                    mul_b = self_weight_reg;
                end
                else if (kind_reg == KIND_INNER)
                begin
                    mul_a = weight_reg;
                    mul_b = vol_reg;
                end
                else
                begin
                    mul_a = weight_reg;
                    mul_b = mass_reg;
                end
            end
            S_MUL2:
            begin
                mul_a = x_cur;
                mul_b = (kind_reg == KIND_WALL) ? inv_sel : rho_reg;
            end
            S_FM1:
            begin
                mul_a = wall_sum_reg[DATA_W-1:0];
                mul_b = own_density_reg;
            end
            S_FM2:
            begin
                mul_a = wall_sum_reg[SUM_W-1:DATA_W];
                mul_b = own_density_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        state_next       = state_reg;
        done_next        = 1'b0;
        x_next           = x_reg;
        lo_next          = lo_reg;
        mf_next          = mf_reg;
        num_sum_next     = num_sum_reg;
        den_sum_next     = den_sum_reg;
        wall_sum_next    = wall_sum_reg;
        own_density_next = own_density_reg;
        own_mass_next    = own_mass_reg;
        fd_next          = fd_reg;
        nv_next          = nv_reg;
        fault_next       = fault_reg;
        div_req.start    = 1'b0;
        div_req.num      = add_sat(num_sum_reg, mf_reg);
        div_req.den      = add_sat(den_sum_reg, wall_sum_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                x_next     = x_cur;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                unique case (kind_reg)
                    KIND_SELF:
                    begin
                        den_sum_next     = widen(x_reg);
                        num_sum_next     = prod_shift;
                        wall_sum_next    = '0;
                        own_density_next = rho_reg;
                        own_mass_next    = mass_reg;
                    end
                    KIND_INNER:
                    begin
                        den_sum_next = add_sat(den_sum_reg, widen(x_reg));
                        num_sum_next = add_sat(num_sum_reg, prod_shift);
                    end
                    KIND_WALL:
                    begin
                        if (body_ok)
                        begin
                            wall_sum_next = add_sat(wall_sum_reg, widen(x_cur));
                        end
                    end
                    default:
                    begin
                        // unused kind: add nothing
                        state_next = state_reg;
                    end
                endcase
                if (last_reg)
                begin
                    state_next = S_FM1;
                end
                else if (accept)
                begin
                    state_next = S_MUL1;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FM1:
            begin
                state_next = S_FM2;
            end
            S_FM2:
            begin
                lo_next    = prod_reg;
                state_next = S_FM3;
            end
            S_FM3:
            begin
                // combine the two partial products of wall_sum * own_density
                if ((prod_reg >> (DATA_W + FRAC_BITS)) != '0)
                begin
                    mf_next = '1;
                end
                else
                begin
                    mf_next = add_sat(prod_reg << (DATA_W - FRAC_BITS), lo_reg >> FRAC_BITS);
                end
                state_next = S_FM4;
            end
            S_FM4:
            begin
                div_req.start = 1'b1;
                state_next    = S_DIV1;
            end
            S_DIV1:
            begin
                div_req.num = widen(own_mass_reg);
                div_req.den = widen(div_res.quot);
                if (div_res.done)
                begin
                    div_req.start = 1'b1;
                    fd_next       = div_res.quot;
                    fault_next    = div_res.fault;
                    state_next    = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (div_res.done)
                begin
                    nv_next    = div_res.quot;
                    fault_next = fault_reg | div_res.fault;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            done_reg        <= 1'b0;
            num_sum_reg     <= '0;
            den_sum_reg     <= '0;
            wall_sum_reg    <= '0;
            own_density_reg <= '0;
            own_mass_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            done_reg        <= done_next;
            num_sum_reg     <= num_sum_next;
            den_sum_reg     <= den_sum_next;
            wall_sum_reg    <= wall_sum_next;
            own_density_reg <= own_density_next;
            own_mass_reg    <= own_mass_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= item_kind;
            weight_reg <= kernel_weight;
            rho_reg    <= density;
            vol_reg    <= volume;
            mass_reg   <= mass;
            body_reg   <= wall_body;
            last_reg   <= last;
        end
        prod_reg  <= prod_next;
        x_reg     <= x_next;
        lo_reg    <= lo_next;
        mf_reg    <= mf_next;
        fd_reg    <= fd_next;
        nv_reg    <= nv_next;
        fault_reg <= fault_next;
    end

    sdfw_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    assign done             = done_reg;
    assign filtered_density = fd_reg;
    assign new_volume       = nv_reg;
    assign divide_fault     = fault_reg;

endmodule

FILE: design/sdfw_checker.sv
module sdfw_checker
    import sdfw_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic [DATA_W-1:0] filtered_density,
    input logic              divide_fault
);

    // a result strobe is never held high
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // an accepted transaction keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a transaction");

    a_accept_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result right after accepting a transaction");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // a zero filtered density always comes with a fault
    a_zero_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (done && filtered_density == '0) |-> divide_fault)
        else $error("zero filtered density without fault");

endmodule

bind shepard_density_filter_wall sdfw_checker u_sdfw_checker (.*);

FILE: verif/tb_shepard_density_filter_wall.sv
module tb_shepard_density_filter_wall;

    import sdfw_pkg::*;

    localparam int FRAC        = 16;
    localparam int WALL_BODIES = 4;
    localparam int CYCLE_LIMIT = 800000;
    localparam int SETTLE      = 100;
    localparam int MAX_REPORTS = 40;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam word_t      ONE        = 32'h0001_0000;
    localparam word_t      ALL_ONES   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0] kind;
        word_t      weight;
        word_t      rho;
        word_t      vol;
        word_t      m;
        logic [1:0] body;
        logic       lst;
    } particle_item_t;

    typedef struct packed {
        word_t fd;
        word_t nv;
        logic  fault;
    } filter_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]    cfg_data = '0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           item_kind = '0;
    logic [DATA_W-1:0]    kernel_weight = '0;
    logic [DATA_W-1:0]    density = '0;
    logic [DATA_W-1:0]    volume = '0;
    logic [DATA_W-1:0]    mass = '0;
    logic [1:0]           wall_body = '0;
    logic                 last = 1'b0;
    logic                 done;
    logic [DATA_W-1:0]    filtered_density;
    logic [DATA_W-1:0]    new_volume;
    logic                 divide_fault;

    // predictor copy of the block state and registers
    sum_t  sum_num = '0;
    sum_t  sum_den = '0;
    sum_t  sum_wall = '0;
    word_t own_rho = '0;
    word_t own_m = '0;
    word_t self_w_reg = ONE;
    word_t wall_inv_reg [WALL_BODIES] = '{default: ONE};

    filter_result_t density_results [$];
    int mismatch_count = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int idle_pct = 0;

    shepard_density_filter_wall dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .start            (start),
        .busy             (busy),
        .item_kind        (item_kind),
        .kernel_weight    (kernel_weight),
        .density          (density),
        .volume           (volume),
        .mass             (mass),
        .wall_body        (wall_body),
        .last             (last),
        .done             (done),
        .filtered_density (filtered_density),
        .new_volume       (new_volume),
        .divide_fault     (divide_fault)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, density_results.size());
            $display("FAIL");
            $finish;
        end
    end

    function automatic sum_t sat_add(input sum_t a, input sum_t b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    function automatic word_t clip32(input sum_t v);
        return (|v[SUM_W-1:DATA_W]) ? '1 : v[DATA_W-1:0];
    endfunction

    // truncated fixed-point product, saturated to 64 bits
    function automatic sum_t fx_mul(input sum_t a, input word_t b);
        logic [SUM_W+DATA_W-1:0] prod;
        prod = ({{DATA_W{1'b0}}, a} * {{SUM_W{1'b0}}, b}) >> FRAC;
        return (|prod[SUM_W+DATA_W-1:SUM_W]) ? '1 : prod[SUM_W-1:0];
    endfunction

    // truncated fixed-point quotient, saturated to 32 bits; den must be nonzero
    function automatic word_t fx_div(input sum_t num, input sum_t den);
        logic [SUM_W+FRAC-1:0] quo;
        quo = {num, {FRAC{1'b0}}} / {{FRAC{1'b0}}, den};
        return (|quo[SUM_W+FRAC-1:DATA_W]) ? '1 : quo[DATA_W-1:0];
    endfunction

    task automatic predict_item(input particle_item_t it);
        word_t          kv;
        word_t          wm;
        word_t          wt;
        word_t          fd;
        word_t          nv;
        sum_t           num_tot;
        sum_t           den_tot;
        logic           fault;
        filter_result_t entry;
        fault = 1'b0;
        case (it.kind)
            KIND_SELF:
            begin
                kv       = clip32(fx_mul(sum_t'(it.vol), self_w_reg));
                sum_den  = sum_t'(kv);
                sum_num  = fx_mul(sum_t'(it.rho), kv);
                sum_wall = '0;
                own_rho  = it.rho;
                own_m    = it.m;
            end
            KIND_INNER:
            begin
                kv      = clip32(fx_mul(sum_t'(it.weight), it.vol));
                sum_den = sat_add(sum_den, sum_t'(kv));
                sum_num = sat_add(sum_num, fx_mul(sum_t'(it.rho), kv));
            end
            KIND_WALL:
            begin
                if (it.body < WALL_BODIES)
                begin
                    wm       = clip32(fx_mul(sum_t'(it.weight), it.m));
                    wt       = clip32(fx_mul(sum_t'(wm), wall_inv_reg[it.body]));
                    sum_wall = sat_add(sum_wall, sum_t'(wt));
                end
            end
            default:
            begin
            end
        endcase
        if (it.lst)
        begin
            den_tot = sat_add(sum_den, sum_wall);
            num_tot = sat_add(sum_num, fx_mul(sum_wall, own_rho));
            if (den_tot == '0)
            begin
                fd    = '1;
                fault = 1'b1;
            end
            else
            begin
                fd = fx_div(num_tot, den_tot);
            end
            if (fd == '0)
            begin
                nv    = '1;
                fault = 1'b1;
            end
            else
            begin
                nv = fx_div(sum_t'(own_m), sum_t'(fd));
            end
            entry = '{fd: fd, nv: nv, fault: fault};
            density_results.insert(density_results.size(), entry);
        end
    endtask

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    endtask

    always @(posedge clk)
    begin : check_result
        filter_result_t want;
        if (rst_n && done)
        begin
            if (density_results.size() == 0)
            begin
                report_mismatch("result with nothing pending", filtered_density, '0);
            end
            else
            begin
                want = density_results.pop_front();
                if (filtered_density !== want.fd)
                    report_mismatch("filtered_density", filtered_density, want.fd);
                if (new_volume !== want.nv)
                    report_mismatch("new_volume", new_volume, want.nv);
                if (divide_fault !== want.fault)
                    report_mismatch("divide_fault", word_t'(divide_fault), word_t'(want.fault));
            end
        end
    end

    function automatic particle_item_t mk_item(input logic [1:0] kind, input word_t weight,
                                               input word_t rho, input word_t vol,
                                               input word_t m, input logic [1:0] body,
                                               input logic lst);
        return '{kind: kind, weight: weight, rho: rho, vol: vol, m: m, body: body, lst: lst};
    endfunction

    // mostly plausible magnitudes, with zeros, all-ones and raw words mixed in
    function automatic word_t pick_word(input int unsigned lo, input int unsigned hi);
        case ($urandom_range(15))
            0:       return '0;
            1:       return ALL_ONES;
            2, 3:    return $urandom();
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    function automatic particle_item_t rand_self(input logic lst);
        return mk_item(KIND_SELF, $urandom(), pick_word(1 << 15, 1 << 17),
                       pick_word(1 << 10, 1 << 16), pick_word(1 << 10, 1 << 18),
                       2'($urandom_range(3)), lst);
    endfunction

    function automatic particle_item_t rand_neighbor(input logic lst);
        if ($urandom_range(2) != 0)
            return mk_item(KIND_INNER, pick_word(0, 1 << 16), pick_word(1 << 15, 1 << 17),
                           pick_word(1 << 10, 1 << 16), $urandom(),
                           2'($urandom_range(3)), lst);
        return mk_item(KIND_WALL, pick_word(0, 1 << 16), $urandom(), $urandom(),
                       pick_word(1 << 10, 1 << 17), 2'($urandom_range(3)), lst);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input word_t val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_SELF_WEIGHT)
            self_w_reg = val;
        else
            wall_inv_reg[idx - REG_WALL_INV_0] = val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_registers(input word_t sw, input word_t w0, input word_t w1,
                                     input word_t w2, input word_t w3);
        write_reg(REG_SELF_WEIGHT, sw);
        write_reg(REG_WALL_INV_0, w0);
        write_reg(CFG_IDX_W'(REG_WALL_INV_0 + 1), w1);
        write_reg(CFG_IDX_W'(REG_WALL_INV_0 + 2), w2);
        write_reg(CFG_IDX_W'(REG_WALL_INV_0 + 3), w3);
    endtask

    task automatic idle_gap();
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
    endtask

    // start stays high after acceptance so back-to-back items need no extra edge
    task automatic send_item(input particle_item_t it);
        idle_gap();
        start         <= 1'b1;
        item_kind     <= it.kind;
        kernel_weight <= it.weight;
        density       <= it.rho;
        volume        <= it.vol;
        mass          <= it.m;
        wall_body     <= it.body;
        last          <= it.lst;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_item(it);
        if (!(it.kind == KIND_SPARE && !it.lst))
            items_sent++;
    endtask

    // hold off until every result is back, then let the block settle
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (density_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_run(input int n_nbr);
        send_item(rand_self(n_nbr == 0));
        for (int k = 0; k < n_nbr; k++)
            send_item(rand_neighbor(k == n_nbr - 1));
    endtask

    task automatic test_reset_state();
        // zero state: nothing to divide by
        send_item(mk_item(KIND_SPARE, $urandom(), $urandom(), $urandom(), $urandom(), 2'd0, 1'b1));
        // neighbors before any self item pile onto the cleared sums
        send_item(mk_item(KIND_INNER, ONE, 32'h0002_0000, 32'h0000_8000, '0, 2'd2, 1'b1));
        send_item(mk_item(KIND_WALL, 32'h0000_C000, '0, '0, 32'h0003_0000, 2'd1, 1'b1));
    endtask

    task automatic test_degenerate_sums();
        // zero own volume leaves a zero weight sum
        send_item(mk_item(KIND_SELF, '0, ONE, '0, ONE, 2'd0, 1'b1));
        // zero density gives a zero filtered density
        send_item(mk_item(KIND_SELF, '0, '0, ONE, ONE, 2'd0, 1'b1));
        // tiny density with huge mass overflows the volume quotient
        send_item(mk_item(KIND_SELF, '0, 32'd1, ONE, ALL_ONES, 2'd0, 1'b1));
    endtask

    task automatic test_run_structure();
        send_item(mk_item(KIND_SELF, '0, 32'h0001_2000, 32'h0000_4000, 32'h0000_8000, 2'd0, 1'b0));
        send_item(mk_item(KIND_INNER, 32'h0000_3000, 32'h0000_F000, 32'h0000_4000, '0, 2'd0, 1'b0));
        // a second self item restarts the run
        send_item(mk_item(KIND_SELF, '0, 32'h0000_F800, 32'h0000_5000, 32'h0000_9000, 2'd0, 1'b0));
        for (int b = 0; b < WALL_BODIES; b++)
            send_item(mk_item(KIND_WALL, 32'h0000_2000 + b, '0, '0, 32'h0000_A000, 2'(b), 1'b0));
        send_item(mk_item(KIND_INNER, 32'h0000_2800, 32'h0001_1000, 32'h0000_4800, '0, 2'd3, 1'b1));
        // neighbor after a finished run keeps accumulating
        send_item(mk_item(KIND_INNER, 32'h0000_1000, 32'h0001_0800, 32'h0000_4000, '0, 2'd1, 1'b1));
    endtask

    task automatic test_field_extremes();
        send_item(mk_item(KIND_SELF, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 2'd3, 1'b0));
        send_item(mk_item(KIND_INNER, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 2'd3, 1'b0));
        send_item(mk_item(KIND_WALL, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, 2'd3, 1'b1));
        send_item(mk_item(KIND_SELF, '0, '0, '0, '0, 2'd0, 1'b0));
        send_item(mk_item(KIND_INNER, '0, '0, '0, '0, 2'd0, 1'b1));
    endtask

    task automatic test_register_extremes();
        drain();
        program_registers('0, '0, '0, '0, '0);
        send_item(mk_item(KIND_SELF, '0, ONE, ONE, ONE, 2'd0, 1'b0));
        send_item(mk_item(KIND_WALL, ONE, '0, '0, ONE, 2'd2, 1'b1));
        drain();
        program_registers(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        send_item(mk_item(KIND_SELF, '0, ONE, ONE, ONE, 2'd0, 1'b0));
        send_item(mk_item(KIND_WALL, ONE, '0, '0, ONE, 2'd0, 1'b0));
        send_item(mk_item(KIND_INNER, ONE, ONE, ONE, '0, 2'd0, 1'b1));
        drain();
    endtask

    task automatic test_random_traffic(input int pct, input int n_items, input bit wide_regs);
        int base;
        int n_nbr;
        base = items_sent;
        if (wide_regs)
            program_registers(pick_word(1 << 12, 1 << 18), pick_word(1 << 12, 1 << 18),
                              pick_word(1 << 12, 1 << 18), pick_word(1 << 12, 1 << 18),
                              pick_word(1 << 12, 1 << 18));
        else
            program_registers($urandom_range(1 << 18, 1 << 14), $urandom_range(1 << 18, 1 << 12),
                              $urandom_range(1 << 18, 1 << 12), $urandom_range(1 << 18, 1 << 12),
                              $urandom_range(1 << 18, 1 << 12));
        idle_pct = pct;
        while (items_sent - base < n_items)
        begin
            if ($urandom_range(9) == 0)
            begin
                // stray transaction: any kind, any flag, raw fields
                send_item(mk_item(2'($urandom_range(3)), $urandom(), $urandom(), $urandom(),
                                  $urandom(), 2'($urandom_range(3)), 1'($urandom_range(1))));
            end
            else
            begin
                n_nbr = ($urandom_range(9) == 0) ? $urandom_range(40, 15) : $urandom_range(12);
                send_run(n_nbr);
            end
            if ($urandom_range(39) == 0)
                drain();
        end
        drain();
        idle_pct = 0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_degenerate_sums();
        test_run_structure();
        test_field_extremes();
        test_register_extremes();
        test_random_traffic(19, 380, 1'b0);
        test_random_traffic(86, 380, 1'b0);
        test_random_traffic(0, 390, 1'b1);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
